/* rtl/assert_macros.svh */
// Assertion macros shared by the SBUS frame decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfd: next-cycle check failed");

`endif

/* rtl/sfd_pkg.sv */
// Types and constants of the SBUS frame decoder.
package sfd_pkg;

    localparam int BYTE_W        = 8;
    localparam int FRAME_LEN     = 25;
    localparam int POS_W         = 5;
    localparam int CH_W          = 4;
    localparam int RAW_W         = 11;
    localparam int PCT_W         = 15;
    localparam int PAYLOAD_BYTES = 22;
    localparam int PAYLOAD_W     = PAYLOAD_BYTES * BYTE_W;
    localparam int PCT_SCALE     = 100 * 256;
    localparam int NUM_W         = 26;
    localparam int DCNT_W        = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = RAW_W;

    // byte positions inside a frame
    localparam logic [POS_W-1:0] POS_HEADER  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_PAY_LO  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_PAY_HI  = POS_W'(PAYLOAD_BYTES);
    localparam logic [POS_W-1:0] POS_FOOTER  = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] POS_FULL    = POS_W'(FRAME_LEN);
    localparam logic [DCNT_W-1:0] DCNT_LAST  = DCNT_W'(PCT_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_MIN    = 2'd0,
        CFG_RANGE_MAX    = 2'd1,
        CFG_HEADER_VALUE = 2'd2,
        CFG_FOOTER_VALUE = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_RECV,
        S_CHECK,
        S_MUL,
        S_DINIT,
        S_DIV,
        S_LOAD,
        S_SEND
    } t_state;

    typedef struct packed {
        logic store_byte;
        logic load_err;
        logic chan_clear;
        logic mul;
        logic div_init;
        logic div_step;
        logic load_out;
        logic next_chan;
    } t_dp_cmd;

    typedef struct packed {
        logic frame_done;
        logic frame_ok;
        logic div_last;
        logic out_last;
    } t_dp_status;

endpackage

/* rtl/sfd_in_if.sv */
// Input byte channel of the SBUS frame decoder.
interface sfd_in_if;
    logic                       valid;
    logic                       ready;
    logic [sfd_pkg::BYTE_W-1:0] rx_byte;
    logic                       frame_start;

    modport source (output valid, rx_byte, frame_start, input ready);
    modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

/* rtl/sfd_out_if.sv */
// Result channel of the SBUS frame decoder.
interface sfd_out_if;
    logic                      valid;
    logic                      ready;
    logic [sfd_pkg::CH_W-1:0]  channel;
    logic [sfd_pkg::RAW_W-1:0] raw_value;
    logic [sfd_pkg::PCT_W-1:0] percent;
    logic                      frame_error;
    logic                      last;

    modport source (output valid, channel, raw_value, percent, frame_error, last,
                    input ready);
    modport sink   (input valid, channel, raw_value, percent, frame_error, last,
                    output ready);
endinterface

/* rtl/sfd_ctrl.sv */
// Sequencer of the SBUS frame decoder: byte intake, frame check, per-channel steps.
`include "assert_macros.svh"

module sfd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  sfd_pkg::t_dp_status i_status,
    output sfd_pkg::t_dp_cmd    o_cmd
);

    sfd_pkg::t_state r_state;
    sfd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfd_pkg::S_RECV;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            sfd_pkg::S_RECV: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.store_byte = 1'b1;
                    if (i_status.frame_done) begin
                        n_state = sfd_pkg::S_CHECK;
                    end
                end
            end
            sfd_pkg::S_CHECK: begin
                if (i_status.frame_ok) begin
                    o_cmd.chan_clear = 1'b1;
                    n_state          = sfd_pkg::S_MUL;
                end else begin
                    o_cmd.load_err = 1'b1;
                    n_state        = sfd_pkg::S_SEND;
                end
            end
            sfd_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = sfd_pkg::S_DINIT;
            end
            sfd_pkg::S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = sfd_pkg::S_DIV;
            end
            sfd_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = sfd_pkg::S_LOAD;
                end
            end
            sfd_pkg::S_LOAD: begin
                o_cmd.load_out = 1'b1;
                n_state        = sfd_pkg::S_SEND;
            end
            sfd_pkg::S_SEND: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.out_last) begin
                        n_state = sfd_pkg::S_RECV;
                    end else begin
                        o_cmd.next_chan = 1'b1;
                        n_state         = sfd_pkg::S_MUL;
                    end
                end
            end
            default: begin
                n_state = sfd_pkg::S_RECV;
            end
        endcase
    end

    // a completed frame stops intake until its results are out
    `SFD_ASSERT_NXT(a_frame_stalls_intake, i_clk, i_rst_n, i_in_valid && o_in_ready && i_status.frame_done, !o_in_ready)
    // the final result of a frame hands control back to intake
    `SFD_ASSERT_NXT(a_last_resumes_intake, i_clk, i_rst_n, o_out_valid && i_out_ready && i_status.out_last, o_in_ready)

endmodule

/* rtl/sfd_datapath.sv */
// Datapath of the SBUS frame decoder: frame store, clamp, scale and divider.
`include "assert_macros.svh"

module sfd_datapath #(
    parameter int CHANNEL_COUNT = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [sfd_pkg::BYTE_W-1:0]      i_rx_byte,
    input  logic                            i_frame_start,
    input  sfd_pkg::t_dp_cmd                i_cmd,
    output sfd_pkg::t_dp_status             o_status,
    output logic [sfd_pkg::CH_W-1:0]        o_channel,
    output logic [sfd_pkg::RAW_W-1:0]       o_raw_value,
    output logic [sfd_pkg::PCT_W-1:0]       o_percent,
    output logic                            o_frame_error,
    output logic                            o_last
);

    localparam logic [sfd_pkg::CH_W-1:0] LastChan = sfd_pkg::CH_W'(CHANNEL_COUNT - 1);

    // configuration
    logic [sfd_pkg::RAW_W-1:0]  r_range_min;
    logic [sfd_pkg::RAW_W-1:0]  r_range_max;
    logic [sfd_pkg::BYTE_W-1:0] r_header;
    logic [sfd_pkg::BYTE_W-1:0] r_footer;

    // frame store
    logic [sfd_pkg::POS_W-1:0]     r_pos;
    logic [sfd_pkg::POS_W-1:0]     pos_eff;
    logic [sfd_pkg::BYTE_W-1:0]    r_hdr_byte;
    logic [sfd_pkg::BYTE_W-1:0]    r_ftr_byte;
    logic [sfd_pkg::PAYLOAD_W-1:0] r_payload;
    logic [sfd_pkg::CH_W-1:0]      r_chan;

    // channel arithmetic
    logic [sfd_pkg::RAW_W-1:0]  raw_in;
    logic [sfd_pkg::RAW_W-1:0]  clamped;
    logic [sfd_pkg::RAW_W-1:0]  r_raw;
    logic                       r_empty;
    logic [sfd_pkg::NUM_W-1:0]  r_num;
    logic [sfd_pkg::RAW_W-1:0]  r_den;
    logic [sfd_pkg::RAW_W-1:0]  r_rem;
    logic [sfd_pkg::PCT_W-1:0]  r_quo;
    logic [sfd_pkg::DCNT_W-1:0] r_dcnt;
    logic [sfd_pkg::RAW_W:0]    trial;
    logic                       trial_ge;

    // result register
    logic [sfd_pkg::CH_W-1:0]  r_out_chan;
    logic [sfd_pkg::RAW_W-1:0] r_out_raw;
    logic [sfd_pkg::PCT_W-1:0] r_out_pct;
    logic                      r_out_err;
    logic                      r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min <= sfd_pkg::RAW_W'(172);
            r_range_max <= sfd_pkg::RAW_W'(1811);
            r_header    <= sfd_pkg::BYTE_W'(8'h0F);
            r_footer    <= sfd_pkg::BYTE_W'(8'h00);
        end else if (i_cfg_we) begin
            unique case (sfd_pkg::t_cfg_idx'(i_cfg_idx))
                sfd_pkg::CFG_RANGE_MIN:    r_range_min <= i_cfg_data;
                sfd_pkg::CFG_RANGE_MAX:    r_range_max <= i_cfg_data;
                sfd_pkg::CFG_HEADER_VALUE: r_header    <= i_cfg_data[sfd_pkg::BYTE_W-1:0];
                sfd_pkg::CFG_FOOTER_VALUE: r_footer    <= i_cfg_data[sfd_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign pos_eff = i_frame_start ? sfd_pkg::POS_HEADER : r_pos;

    // byte position saturates at a full frame; stray bytes leave it there
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_cmd.store_byte) begin
            if (pos_eff < sfd_pkg::POS_FULL) begin
                r_pos <= pos_eff + sfd_pkg::POS_W'(1);
            end else begin
                r_pos <= pos_eff;
            end
        end
    end

    // payload bytes shift in from the top, so byte 1 ends at bit 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte) begin
            if (pos_eff == sfd_pkg::POS_HEADER) begin
                r_hdr_byte <= i_rx_byte;
            end
            if (pos_eff == sfd_pkg::POS_FOOTER) begin
                r_ftr_byte <= i_rx_byte;
            end
            if (pos_eff >= sfd_pkg::POS_PAY_LO && pos_eff <= sfd_pkg::POS_PAY_HI) begin
                r_payload <= {i_rx_byte, r_payload[sfd_pkg::PAYLOAD_W-1:sfd_pkg::BYTE_W]};
            end
        end else if (i_cmd.next_chan) begin
            r_payload <= {sfd_pkg::RAW_W'(0), r_payload[sfd_pkg::PAYLOAD_W-1:sfd_pkg::RAW_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.chan_clear) begin
            r_chan <= '0;
        end else if (i_cmd.next_chan) begin
            r_chan <= r_chan + sfd_pkg::CH_W'(1);
        end
    end

    assign raw_in = r_payload[sfd_pkg::RAW_W-1:0];

    always_comb begin
        if (raw_in < r_range_min) begin
            clamped = r_range_min;
        end else if (raw_in > r_range_max) begin
            clamped = r_range_max;
        end else begin
            clamped = raw_in;
        end
    end

    // scale: (raw - min) * 25600, divided below by (max - min)
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_raw   <= clamped;
            r_empty <= (r_range_max <= r_range_min);
            r_num   <= sfd_pkg::NUM_W'(clamped - r_range_min)
                       * sfd_pkg::NUM_W'(sfd_pkg::PCT_SCALE);
            r_den   <= r_range_max - r_range_min;
        end
    end

    // restoring divider, one quotient bit per cycle
    assign trial    = {r_rem, r_quo[sfd_pkg::PCT_W-1]};
    assign trial_ge = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem  <= r_num[sfd_pkg::NUM_W-1:sfd_pkg::PCT_W];
            r_quo  <= r_num[sfd_pkg::PCT_W-1:0];
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= trial_ge ? sfd_pkg::RAW_W'(trial - {1'b0, r_den})
                               : trial[sfd_pkg::RAW_W-1:0];
            r_quo  <= {r_quo[sfd_pkg::PCT_W-2:0], trial_ge};
            r_dcnt <= r_dcnt + sfd_pkg::DCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_err) begin
            r_out_chan <= '0;
            r_out_raw  <= '0;
            r_out_pct  <= '0;
            r_out_err  <= 1'b1;
            r_out_last <= 1'b1;
        end else if (i_cmd.load_out) begin
            r_out_chan <= r_chan;
            r_out_raw  <= r_raw;
            r_out_pct  <= r_empty ? '0 : r_quo;
            r_out_err  <= 1'b0;
            r_out_last <= (r_chan == LastChan);
        end
    end

    assign o_status.frame_done = (pos_eff == sfd_pkg::POS_FOOTER);
    assign o_status.frame_ok   = (r_hdr_byte == r_header) && (r_ftr_byte == r_footer);
    assign o_status.div_last   = (r_dcnt == sfd_pkg::DCNT_LAST);
    assign o_status.out_last   = r_out_last;

    assign o_channel     = r_out_chan;
    assign o_raw_value   = r_out_raw;
    assign o_percent     = r_out_pct;
    assign o_frame_error = r_out_err;
    assign o_last        = r_out_last;

    // partial remainder stays below the divisor for a non-empty range
    `SFD_ASSERT_IMP(a_rem_below_den, i_clk, i_rst_n, i_cmd.div_step && !r_empty, r_rem < r_den)
    // a finished quotient never exceeds full scale
    `SFD_ASSERT_IMP(a_quo_in_range, i_clk, i_rst_n, i_cmd.load_out && !r_empty, r_quo <= sfd_pkg::PCT_W'(sfd_pkg::PCT_SCALE))

endmodule

/* rtl/sbus_frame_decoder_core.sv */
// SBUS 16-channel frame decoder top level: controller plus datapath.
// Intake takes one byte per cycle while idle; the 25th byte of a frame stops intake.
// Then a check state, and per channel clamp/scale, divider load, 15 divide steps,
// result load and result transfer: a good frame holds intake until its last result is out.
// A bad frame gives its single error result, loaded in the check state and offered in the send state.
// Synchronous active-low reset clears sequencer and byte position, restores config defaults.
module sbus_frame_decoder_core #(
    parameter int CHANNEL_COUNT = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sfd_in_if.sink                         i_in,
    sfd_out_if.source                      o_out
);

    // command and status between sequencer and datapath
    sfd_pkg::t_dp_cmd    cmd;
    sfd_pkg::t_dp_status status;

    // The sequencer owns both handshakes: bytes are taken only in its intake
    // state, and each result waits in the datapath's output register until
    // its transfer completes.
    sfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath keeps the configuration, header/footer bytes and the
    // 22 payload bytes as a shift line; each channel is the low 11 bits,
    // shifted out after its result transfer. Percent comes from a
    // multiply by 25600 and a bit-serial divide by the range width.
    sfd_datapath #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_rx_byte     (i_in.rx_byte),
        .i_frame_start (i_in.frame_start),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_channel     (o_out.channel),
        .o_raw_value   (o_out.raw_value),
        .o_percent     (o_out.percent),
        .o_frame_error (o_out.frame_error),
        .o_last        (o_out.last)
    );

endmodule

/* dv/sbus_frame_decoder_core_tb.sv */
// Self-checking testbench of the SBUS frame decoder core: directed frame table, then random frames.
module sbus_frame_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_CH      = 16;
    localparam int IDLE_TAIL = 32;   // cycles after the last result before a register write

    // Directed rows either trust the predictor or carry a hand-typed expectation.
    typedef enum {
        CHK_PREDICT,
        CHK_CHANNELS,   // every channel gives the typed raw value and percent
        CHK_ERROR       // single error result
    } t_row_check;

    typedef struct packed {
        logic [sfd_pkg::CH_W-1:0]  channel;
        logic [sfd_pkg::RAW_W-1:0] raw_value;
        logic [sfd_pkg::PCT_W-1:0] percent;
        logic                      frame_error;
        logic                      last;
    } t_chan_result;

    typedef struct {
        logic [sfd_pkg::RAW_W-1:0]  lo;
        logic [sfd_pkg::RAW_W-1:0]  hi;
        logic [sfd_pkg::BYTE_W-1:0] hdr;
        logic [sfd_pkg::BYTE_W-1:0] ftr;
        logic [sfd_pkg::BYTE_W-1:0] head;
        logic [sfd_pkg::BYTE_W-1:0] foot;
        bit                         first_start;
        int unsigned                lead;      // bytes of an aborted frame sent first
        int unsigned                strays;    // bytes after the frame, to be ignored
        bit                         rand_fill;
        logic [sfd_pkg::RAW_W-1:0]  fill;
        t_row_check                 check;
        logic [sfd_pkg::RAW_W-1:0]  exp_raw;
        logic [sfd_pkg::PCT_W-1:0]  exp_pct;
    } t_frame_row;

    // lo, hi, hdr, ftr | head, foot | start, lead, strays | rand, fill | check, raw, pct
    t_frame_row frame_rows [5] = '{
        // first frame after reset comes without a restart flag
        '{11'd172, 11'd1811, 8'h0F, 8'h00, 8'h0F, 8'h00, 1'b0, 0, 0,
          1'b0, 11'd0, CHK_CHANNELS, 11'd172, 15'd0},
        // bad header, then stray bytes
        '{11'd172, 11'd1811, 8'h0F, 8'h00, 8'hF0, 8'h00, 1'b1, 0, 2,
          1'b1, 11'd0, CHK_ERROR, 11'd0, 15'd0},
        // restart in the middle of a frame, full-scale clamp
        '{11'd172, 11'd1811, 8'h0F, 8'h00, 8'h0F, 8'h00, 1'b1, 4, 0,
          1'b0, 11'd2047, CHK_CHANNELS, 11'd1811, 15'd25600},
        '{11'd0, 11'd2047, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 0, 0,
          1'b1, 11'd0, CHK_PREDICT, 11'd0, 15'd0},
        // empty range: min above max
        '{11'd1500, 11'd200, 8'h80, 8'h7F, 8'h80, 8'h7F, 1'b1, 0, 0,
          1'b0, 11'd1000, CHK_CHANNELS, 11'd1500, 15'd0}
    };

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [sfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_data;

    sfd_in_if  in_if ();
    sfd_out_if out_if ();

    sbus_frame_decoder_core #(
        .CHANNEL_COUNT(N_CH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Predictor state: register copies, received bytes and fill position.
    logic [sfd_pkg::RAW_W-1:0]  lo_reg  = 11'd172;
    logic [sfd_pkg::RAW_W-1:0]  hi_reg  = 11'd1811;
    logic [sfd_pkg::BYTE_W-1:0] hdr_reg = 8'h0F;
    logic [sfd_pkg::BYTE_W-1:0] ftr_reg = 8'h00;
    logic [sfd_pkg::BYTE_W-1:0] frame_mem [sfd_pkg::FRAME_LEN];
    int unsigned                fill_pos = 0;

    t_chan_result               pending_results [$];
    t_row_check                 typed_check = CHK_PREDICT;
    logic [sfd_pkg::RAW_W-1:0]  typed_raw;
    logic [sfd_pkg::PCT_W-1:0]  typed_pct;

    bit                         src_calm  = 1'b0;
    bit                         sink_calm = 1'b0;
    int unsigned                fail_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly no gap, some short, a few long.
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Raw channel value, biased toward the clamp edges and the field extremes.
    function automatic logic [sfd_pkg::RAW_W-1:0] pick_chan();
        case ($urandom_range(0, 5))
            0:       return lo_reg;
            1:       return hi_reg;
            2:       return '0;
            3:       return '1;
            4:       return lo_reg + sfd_pkg::RAW_W'($urandom_range(0, 4))
                            - sfd_pkg::RAW_W'(2);
            default: return sfd_pkg::RAW_W'($urandom_range(0, 2047));
        endcase
    endfunction

    function automatic logic [sfd_pkg::PAYLOAD_W-1:0] build_payload(
        input bit rand_fill, input logic [sfd_pkg::RAW_W-1:0] fill);
        logic [sfd_pkg::PAYLOAD_W-1:0] pay;
        pay = '0;
        for (int ch = 0; ch < N_CH; ch++) begin
            pay[sfd_pkg::RAW_W*ch +: sfd_pkg::RAW_W] = rand_fill ? pick_chan() : fill;
        end
        return pay;
    endfunction

    // Frame assembly and channel decode for one accepted byte.
    function automatic void decode_byte(input logic [sfd_pkg::BYTE_W-1:0] b,
                                        input logic restart);
        t_chan_result                  fresh [$];
        logic [sfd_pkg::PAYLOAD_W-1:0] pay;
        logic [sfd_pkg::RAW_W-1:0]     raw;
        logic [31:0]                   pct;
        if (restart) fill_pos = 0;
        if (fill_pos >= sfd_pkg::FRAME_LEN) return;   // stray byte after a full frame
        frame_mem[fill_pos] = b;
        fill_pos++;
        if (fill_pos != sfd_pkg::FRAME_LEN) return;

        if (frame_mem[0] != hdr_reg || frame_mem[sfd_pkg::FRAME_LEN-1] != ftr_reg) begin
            fresh.push_back('{channel: '0, raw_value: '0, percent: '0,
                              frame_error: 1'b1, last: 1'b1});
        end else begin
            for (int i = 0; i < sfd_pkg::PAYLOAD_BYTES; i++)
                pay[sfd_pkg::BYTE_W*i +: sfd_pkg::BYTE_W] = frame_mem[1+i];
            for (int ch = 0; ch < N_CH; ch++) begin
                raw = pay[sfd_pkg::RAW_W*ch +: sfd_pkg::RAW_W];
                if (raw < lo_reg) raw = lo_reg;
                else if (raw > hi_reg) raw = hi_reg;
                pct = 0;
                if (hi_reg > lo_reg && raw >= lo_reg)
                    pct = ((32'(raw) - 32'(lo_reg)) * 32'(sfd_pkg::PCT_SCALE)) /
                          (32'(hi_reg) - 32'(lo_reg));
                fresh.push_back('{channel: sfd_pkg::CH_W'(ch), raw_value: raw,
                                  percent: sfd_pkg::PCT_W'(pct),
                                  frame_error: 1'b0, last: (ch == N_CH - 1)});
            end
        end

        // Hand-typed rows override what was just computed.
        if (typed_check == CHK_ERROR) begin
            fresh = '{'{channel: '0, raw_value: '0, percent: '0, frame_error: 1'b1, last: 1'b1}};
        end else if (typed_check == CHK_CHANNELS) begin
            fresh.delete();
            for (int ch = 0; ch < N_CH; ch++)
                fresh.push_back('{channel: sfd_pkg::CH_W'(ch), raw_value: typed_raw,
                                  percent: typed_pct, frame_error: 1'b0,
                                  last: (ch == N_CH - 1)});
        end
        foreach (fresh[i]) pending_results.push_back(fresh[i]);
    endfunction

    // One input transfer; valid is only lowered when a gap precedes this byte.
    task automatic send_byte(input logic [sfd_pkg::BYTE_W-1:0] b, input logic restart);
        int unsigned gap;
        gap = pick_gap(src_calm);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.rx_byte     <= b;
        in_if.frame_start <= restart;
        do @(posedge i_clk); while (!in_if.ready);
        decode_byte(b, restart);
    endtask

    // Sends the first n_bytes of a frame; byte 23 (flags) carries random content.
    task automatic send_frame(input logic [sfd_pkg::BYTE_W-1:0] head,
                              input logic [sfd_pkg::BYTE_W-1:0] foot,
                              input logic [sfd_pkg::PAYLOAD_W-1:0] pay,
                              input logic first_start, input int unsigned n_bytes);
        logic [sfd_pkg::BYTE_W-1:0] fb [sfd_pkg::FRAME_LEN];
        fb[0] = head;
        for (int i = 0; i < sfd_pkg::PAYLOAD_BYTES; i++)
            fb[1+i] = pay[sfd_pkg::BYTE_W*i +: sfd_pkg::BYTE_W];
        fb[sfd_pkg::FRAME_LEN-2] = sfd_pkg::BYTE_W'($urandom);
        fb[sfd_pkg::FRAME_LEN-1] = foot;
        for (int i = 0; i < n_bytes; i++) send_byte(fb[i], (i == 0) ? first_start : 1'b0);
    endtask

    task automatic wait_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic settle();
        wait_results();
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    task automatic write_reg(input sfd_pkg::t_cfg_idx idx,
                             input logic [sfd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            sfd_pkg::CFG_RANGE_MIN:    lo_reg  = data;
            sfd_pkg::CFG_RANGE_MAX:    hi_reg  = data;
            sfd_pkg::CFG_HEADER_VALUE: hdr_reg = data[sfd_pkg::BYTE_W-1:0];
            sfd_pkg::CFG_FOOTER_VALUE: ftr_reg = data[sfd_pkg::BYTE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [sfd_pkg::RAW_W-1:0] lo,
                             input logic [sfd_pkg::RAW_W-1:0] hi,
                             input logic [sfd_pkg::CFG_DATA_W-1:0] hdr,
                             input logic [sfd_pkg::CFG_DATA_W-1:0] ftr);
        settle();
        write_reg(sfd_pkg::CFG_RANGE_MIN, lo);
        write_reg(sfd_pkg::CFG_RANGE_MAX, hi);
        write_reg(sfd_pkg::CFG_HEADER_VALUE, hdr);
        write_reg(sfd_pkg::CFG_FOOTER_VALUE, ftr);
    endtask

    // Random traffic under one register setting: mostly well-formed frames,
    // the rest bad header/footer, truncated frames and loose noise bytes.
    task automatic run_phase(input bit calm_src, input bit calm_sink, input int unsigned budget);
        int unsigned                sent;
        int unsigned                n;
        int unsigned                pick;
        logic [sfd_pkg::BYTE_W-1:0] head;
        logic [sfd_pkg::BYTE_W-1:0] foot;
        src_calm  = calm_src;
        sink_calm = calm_sink;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 99);
            head = hdr_reg;
            foot = ftr_reg;
            if (pick >= 91) begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(sfd_pkg::BYTE_W'($urandom), 1'($urandom));
            end else if (pick >= 83) begin
                n = $urandom_range(1, sfd_pkg::FRAME_LEN - 1);
                send_frame(head, foot, build_payload(1'b1, '0), 1'b1, n);
            end else begin
                if (pick >= 75) foot ^= sfd_pkg::BYTE_W'($urandom_range(1, 255));
                else if (pick >= 65) head ^= sfd_pkg::BYTE_W'($urandom_range(1, 255));
                n = sfd_pkg::FRAME_LEN;
                send_frame(head, foot, build_payload(1'b1, '0), 1'b1, n);
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 4)) send_byte(sfd_pkg::BYTE_W'($urandom), 1'b0);
                // hold the sender until the decoder has drained
                if ($urandom_range(0, 5) == 0) wait_results();
            end
            sent += n;
        end
        src_calm  = 1'b0;
        sink_calm = 1'b0;
    endtask

    // Result sink with random stalls.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) stall_left--;
            else if (!sink_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap(1'b0);
            out_if.ready <= (stall_left == 0);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Each result transfer is matched against the oldest pending expectation.
    always @(posedge i_clk) begin : result_check
        t_chan_result want;
        t_chan_result got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{channel: out_if.channel, raw_value: out_if.raw_value,
                    percent: out_if.percent, frame_error: out_if.frame_error,
                    last: out_if.last};
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: channel %0d, frame_error %0b",
                       got.channel, got.frame_error);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("channel", 32'(want.channel), 32'(got.channel));
                check_field("raw_value", 32'(want.raw_value), 32'(got.raw_value));
                check_field("percent", 32'(want.percent), 32'(got.percent));
                check_field("frame_error", 32'(want.frame_error), 32'(got.frame_error));
                check_field("last", 32'(want.last), 32'(got.last));
            end
        end
    end

    initial begin
        t_frame_row row;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= sfd_pkg::CFG_RANGE_MIN;
        i_cfg_data        <= '0;
        in_if.valid       <= 1'b0;
        in_if.rx_byte     <= '0;
        in_if.frame_start <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (frame_rows[i]) begin
            row = frame_rows[i];
            if (row.lo != lo_reg || row.hi != hi_reg || row.hdr != hdr_reg || row.ftr != ftr_reg)
                write_all(row.lo, row.hi, sfd_pkg::CFG_DATA_W'(row.hdr),
                          sfd_pkg::CFG_DATA_W'(row.ftr));
            for (int k = 0; k < row.lead; k++) send_byte(sfd_pkg::BYTE_W'($urandom), k == 0);
            typed_check = row.check;
            typed_raw   = row.exp_raw;
            typed_pct   = row.exp_pct;
            send_frame(row.head, row.foot, build_payload(row.rand_fill, row.fill),
                       row.first_start, sfd_pkg::FRAME_LEN);
            typed_check = CHK_PREDICT;
            repeat (row.strays) send_byte(sfd_pkg::BYTE_W'($urandom), 1'b0);
        end

        // Random phase; header/footer writes carry junk in the unused upper bits
        write_all(sfd_pkg::RAW_W'($urandom_range(0, 1000)),
                  sfd_pkg::RAW_W'($urandom_range(1001, 2047)),
                  sfd_pkg::CFG_DATA_W'($urandom), sfd_pkg::CFG_DATA_W'($urandom));
        run_phase(1'b0, 1'b0, 30);

        settle();
        if (fail_count == 0) begin
            $display("sbus_frame_decoder_core: match");
        end else begin
            $display("sbus_frame_decoder_core: mismatch");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("sbus_frame_decoder_core: mismatch");
        $finish;
    end

endmodule
